// ===== hdl/gmsd_pkg.sv =====
// Package with the shared types, widths and constants of the grouped mean and deviation core.
`default_nettype none

package gmsd_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int GROUP_WIDTH = 8;
   localparam int COUNT_WIDTH = 8;
   localparam int STD_WIDTH = 23;
   localparam int SUM_WIDTH = SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int SUMSQ_WIDTH = 2 * SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int PROD_WIDTH = SUMSQ_WIDTH + COUNT_WIDTH;
   localparam int DIVISOR_WIDTH = 2 * COUNT_WIDTH;
   localparam int STEP_WIDTH = $clog2(PROD_WIDTH);
   localparam int MAX_GROUP_LEN = 255;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_value;
      logic sample_present;
      logic [GROUP_WIDTH-1:0] group_id;
      logic end_of_data;
   } req_type;

   typedef struct packed {
      logic [GROUP_WIDTH-1:0] closed_group;
      logic signed [SAMPLE_WIDTH-1:0] group_mean;
      logic [STD_WIDTH-1:0] group_std_dev;
      logic [COUNT_WIDTH-1:0] present_count;
      logic mean_defined;
      logic std_defined;
      logic count_overflow;
      logic last_result;
   } rsp_type;

   typedef struct packed {
      logic [GROUP_WIDTH-1:0] group;
      logic signed [SUM_WIDTH-1:0] sum;
      logic [SUMSQ_WIDTH-1:0] sumsq;
      logic [COUNT_WIDTH-1:0] count;
      logic overflow;
      logic last;
   } group_rec_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_LOAD,
      BACK_DIV_MEAN,
      BACK_NUM,
      BACK_DIV_VAR,
      BACK_SQRT,
      BACK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ===== hdl/gmsd_front.sv =====
// Front end: accepts samples, keeps the running sums of the open group and queues closed groups.
`default_nettype none

module gmsd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire gmsd_pkg::req_type     req_data,
   input  wire logic                  queue_full,
   output logic                       push_valid,
   output gmsd_pkg::group_rec_type    push_data
);
   import gmsd_pkg::*;

   logic [GROUP_WIDTH-1:0] open_group_ff, open_group_in;
   logic active_ff, active_in;
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [SUMSQ_WIDTH-1:0] sumsq_ff, sumsq_in;
   logic [COUNT_WIDTH-1:0] vcount_ff, vcount_in;
   logic [COUNT_WIDTH-1:0] lcount_ff, lcount_in;
   logic ovf_ff, ovf_in;
   logic flush_ff, flush_in;

   logic accept;
   logic change;
   logic fresh;
   logic signed [SUM_WIDTH-1:0] base_sum;
   logic [SUMSQ_WIDTH-1:0] base_sumsq;
   logic [COUNT_WIDTH-1:0] base_vcount;
   logic [COUNT_WIDTH-1:0] base_lcount;
   logic base_ovf;
   logic signed [2*SAMPLE_WIDTH-1:0] square;
   logic signed [SUM_WIDTH-1:0] sample_ext;

   assign req_stall = flush_ff || queue_full;
   assign accept = req_valid && !req_stall;
   assign change = active_ff && (req_data.group_id != open_group_ff);
   assign fresh = !active_ff || change;
   assign square = (2*SAMPLE_WIDTH)'(req_data.sample_value)
                 * (2*SAMPLE_WIDTH)'(req_data.sample_value);
   assign sample_ext = {{(SUM_WIDTH-SAMPLE_WIDTH){req_data.sample_value[SAMPLE_WIDTH-1]}},
                        req_data.sample_value};

   always_comb begin
      base_sum = fresh ? '0 : sum_ff;
      base_sumsq = fresh ? '0 : sumsq_ff;
      base_vcount = fresh ? '0 : vcount_ff;
      base_lcount = fresh ? '0 : lcount_ff;
      base_ovf = fresh ? 1'b0 : ovf_ff;

      open_group_in = open_group_ff;
      active_in = active_ff;
      sum_in = sum_ff;
      sumsq_in = sumsq_ff;
      vcount_in = vcount_ff;
      lcount_in = lcount_ff;
      ovf_in = ovf_ff;
      flush_in = flush_ff;

      push_valid = 1'b0;
      push_data.group = open_group_ff;
      push_data.sum = sum_ff;
      push_data.sumsq = sumsq_ff;
      push_data.count = vcount_ff;
      push_data.overflow = ovf_ff;
      push_data.last = 1'b1;

      if (accept) begin
         push_valid = change;
         push_data.last = !req_data.end_of_data;
         open_group_in = req_data.group_id;
         active_in = 1'b1;
         flush_in = req_data.end_of_data;
         sum_in = base_sum;
         sumsq_in = base_sumsq;
         vcount_in = base_vcount;
         lcount_in = base_lcount;
         ovf_in = base_ovf;
         if (base_lcount >= COUNT_WIDTH'(MAX_GROUP_LEN)) begin
            ovf_in = 1'b1;
         end else begin
            lcount_in = base_lcount + COUNT_WIDTH'(1);
            if (req_data.sample_present) begin
               sum_in = base_sum + sample_ext;
               sumsq_in = base_sumsq + {{(SUMSQ_WIDTH-2*SAMPLE_WIDTH){1'b0}}, square};
               vcount_in = base_vcount + COUNT_WIDTH'(1);
            end
         end
      end else if (flush_ff && !queue_full) begin
         push_valid = 1'b1;
         active_in = 1'b0;
         flush_in = 1'b0;
         sum_in = '0;
         sumsq_in = '0;
         vcount_in = '0;
         lcount_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_group_ff <= '0;
         active_ff <= 1'b0;
         sum_ff <= '0;
         sumsq_ff <= '0;
         vcount_ff <= '0;
         lcount_ff <= '0;
         ovf_ff <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         open_group_ff <= open_group_in;
         active_ff <= active_in;
         sum_ff <= sum_in;
         sumsq_ff <= sumsq_in;
         vcount_ff <= vcount_in;
         lcount_ff <= lcount_in;
         ovf_ff <= ovf_in;
         flush_ff <= flush_in;
      end
   end

`ifndef SYNTH
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("Front pushed a closed group into a full queue.");

   a_eod_flush: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_data) |=> (flush_ff && active_ff))
      else $error("End of data did not schedule the closing transfer.");
`endif

endmodule

`default_nettype wire

// ===== hdl/gmsd_queue.sv =====
// Queue of closed group records between the front end and the arithmetic back end.
`default_nettype none

module gmsd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire gmsd_pkg::group_rec_type push_data,
   output logic                       full,
   input  wire logic                  pop,
   output gmsd_pkg::group_rec_type    head_data,
   output logic                       empty
);
   import gmsd_pkg::*;

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   group_rec_type entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop = pop && !empty;
   assign head_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("Queue fill count ran past its depth.");
`endif

endmodule

`default_nettype wire

// ===== hdl/gmsd_back.sv =====
// Back end: mean, variance division and square root of one closed group, with the result register.
`default_nettype none

module gmsd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire gmsd_pkg::group_rec_type q_head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output gmsd_pkg::rsp_type          rsp_data
);
   import gmsd_pkg::*;

   localparam logic [STD_WIDTH-1:0] STD_MAX = '1;

   back_state_type state_ff, state_in;
   group_rec_type rec_ff, rec_in;
   logic [PROD_WIDTH-1:0] prod_a_ff, prod_a_in;
   logic [PROD_WIDTH-1:0] prod_b_ff, prod_b_in;
   logic [PROD_WIDTH-1:0] quot_ff, quot_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] divisor_ff, divisor_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [PROD_WIDTH-1:0] sq_x_ff, sq_x_in;
   logic [PROD_WIDTH-1:0] sq_res_ff, sq_res_in;
   logic [PROD_WIDTH-1:0] sq_bit_ff, sq_bit_in;
   logic [SAMPLE_WIDTH-1:0] mean_ff, mean_in;
   logic [STD_WIDTH-1:0] std_ff, std_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic slot_free;
   logic sum_neg;
   logic [SUM_WIDTH-1:0] sum_mag;
   logic [DIVISOR_WIDTH:0] trial;
   logic div_ge;
   logic [DIVISOR_WIDTH-1:0] rem_next;
   logic [PROD_WIDTH-1:0] quot_next;
   logic [SAMPLE_WIDTH-1:0] q_low;
   logic [PROD_WIDTH-1:0] sq_t;
   logic sq_ge;
   logic [PROD_WIDTH-1:0] sq_res_next;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign sum_neg = rec_ff.sum[SUM_WIDTH-1];
   assign sum_mag = sum_neg ? SUM_WIDTH'(-rec_ff.sum) : SUM_WIDTH'(rec_ff.sum);

   assign trial = {rem_ff, quot_ff[PROD_WIDTH-1]};
   assign div_ge = trial >= {1'b0, divisor_ff};
   assign rem_next = div_ge ? DIVISOR_WIDTH'(trial - {1'b0, divisor_ff})
                            : trial[DIVISOR_WIDTH-1:0];
   assign quot_next = {quot_ff[PROD_WIDTH-2:0], div_ge};
   assign q_low = quot_next[SAMPLE_WIDTH-1:0];

   assign sq_t = sq_res_ff + sq_bit_ff;
   assign sq_ge = sq_x_ff >= sq_t;
   assign sq_res_next = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               state_in = BACK_LOAD;
            end
         end
         BACK_LOAD: begin
            state_in = (rec_ff.count == '0) ? BACK_DONE : BACK_DIV_MEAN;
         end
         BACK_DIV_MEAN: begin
            if (step_ff == '0) begin
               state_in = (rec_ff.count >= COUNT_WIDTH'(2)) ? BACK_NUM : BACK_DONE;
            end
         end
         BACK_NUM: begin
            state_in = BACK_DIV_VAR;
         end
         BACK_DIV_VAR: begin
            if (step_ff == '0) begin
               state_in = BACK_SQRT;
            end
         end
         BACK_SQRT: begin
            if (sq_bit_ff[0]) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (slot_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop = 1'b0;
      rec_in = rec_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      step_in = step_ff;
      sq_x_in = sq_x_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      mean_in = mean_ff;
      std_in = std_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;

      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               rec_in = q_head;
            end
         end
         BACK_LOAD: begin
            prod_a_in = PROD_WIDTH'(rec_ff.count) * PROD_WIDTH'(rec_ff.sumsq);
            prod_b_in = PROD_WIDTH'(sum_mag) * PROD_WIDTH'(sum_mag);
            quot_in = PROD_WIDTH'(sum_mag);
            rem_in = '0;
            divisor_in = DIVISOR_WIDTH'(rec_ff.count);
            step_in = STEP_WIDTH'(PROD_WIDTH - 1);
            mean_in = '0;
            std_in = '0;
         end
         BACK_DIV_MEAN: begin
            quot_in = quot_next;
            rem_in = rem_next;
            step_in = step_ff - STEP_WIDTH'(1);
            if (step_ff == '0) begin
               mean_in = sum_neg ? (~q_low + SAMPLE_WIDTH'(rem_next == '0)) : q_low;
            end
         end
         BACK_NUM: begin
            quot_in = prod_a_ff - prod_b_ff;
            rem_in = '0;
            divisor_in = DIVISOR_WIDTH'(rec_ff.count)
                       * DIVISOR_WIDTH'(rec_ff.count - COUNT_WIDTH'(1));
            step_in = STEP_WIDTH'(PROD_WIDTH - 1);
         end
         BACK_DIV_VAR: begin
            quot_in = quot_next;
            rem_in = rem_next;
            step_in = step_ff - STEP_WIDTH'(1);
            if (step_ff == '0) begin
               sq_x_in = quot_next;
               sq_res_in = '0;
               sq_bit_in = {2'b01, {(PROD_WIDTH-2){1'b0}}};
            end
         end
         BACK_SQRT: begin
            sq_x_in = sq_ge ? sq_x_ff - sq_t : sq_x_ff;
            sq_res_in = sq_res_next;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               std_in = (sq_res_next > PROD_WIDTH'(STD_MAX)) ? STD_MAX
                                                              : sq_res_next[STD_WIDTH-1:0];
            end
         end
         BACK_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.closed_group = rec_ff.group;
               rsp_data_in.group_mean = mean_ff;
               rsp_data_in.group_std_dev = std_ff;
               rsp_data_in.present_count = rec_ff.count;
               rsp_data_in.mean_defined = (rec_ff.count != '0);
               rsp_data_in.std_defined = (rec_ff.count >= COUNT_WIDTH'(2));
               rsp_data_in.count_overflow = rec_ff.overflow;
               rsp_data_in.last_result = rec_ff.last;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      step_ff <= step_in;
      sq_x_ff <= sq_x_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      mean_ff <= mean_in;
      std_ff <= std_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("Back end popped an empty queue.");

   a_defined_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.std_defined || rsp_data_ff.mean_defined))
      else $error("Deviation flagged defined without a defined mean.");

   a_sqrt_needs_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_SQRT) |-> (rec_ff.count >= COUNT_WIDTH'(2)))
      else $error("Square root started for a group with fewer than two samples.");
`endif

endmodule

`default_nettype wire

// ===== hdl/grouped_mean_std_dev_core.sv =====
// A sample is taken while req_stall is low; a sample with end of data then stalls the input until
// its closing record is pushed into the queue. A closed group's result comes from mean division,
// then, for two or more present samples, variance division and square root on one shared back end.
// Throughput: one sample per cycle while req_stall is low; the back end takes a new closed group
// only after the last is done, from a queue of QUEUE_DEPTH records; input stalls once it is full.
// Reset is synchronous and active high; it leaves no group open and clears queue and result valid.
`default_nettype none

module grouped_mean_std_dev_core #(
   parameter int QUEUE_DEPTH = gmsd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire gmsd_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output gmsd_pkg::rsp_type       rsp_data
);
   import gmsd_pkg::*;

   logic push_valid;
   group_rec_type push_data;
   logic queue_full;
   logic queue_empty;
   logic queue_pop;
   group_rec_type queue_head;

   gmsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   gmsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_data  (queue_head),
      .empty      (queue_empty)
   );

   gmsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (queue_empty),
      .q_head    (queue_head),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/grouped_mean_std_dev_core_tb.sv =====
// Testbench for the grouped mean and standard deviation core: directed table, random groups, scoreboard.
`timescale 1ns / 1ps

module grouped_mean_std_dev_core_tb;
   import gmsd_pkg::*;

   localparam int RANDOM_ITEMS = 1025;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 400;
   localparam int PRINT_LIMIT = 200;
   localparam bit [63:0] STD_LIMIT = (64'd1 << STD_WIDTH) - 64'd1;

   typedef enum int {
      SPREAD_WIDE,
      SPREAD_NARROW,
      SPREAD_EXTREME
   } value_mode_type;

   typedef struct packed {
      req_type item;
      logic    literal;
      rsp_type outcome;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [24] = '{
      '{'{24'sh000001, 1'b1, 8'd0, 1'b1}, 1'b1,
        '{8'd0, 24'sh000001, 23'd0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{'{24'sh123456, 1'b0, 8'd255, 1'b1}, 1'b1,
        '{8'd255, 24'sh000000, 23'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{24'sh7FFFFF, 1'b1, 8'd1, 1'b0}, 1'b0, '0},
      '{'{24'sh800000, 1'b1, 8'd1, 1'b1}, 1'b1,
        '{8'd1, 24'shFFFFFF, 23'h7FFFFF, 8'd2, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{'{24'sh005000, 1'b1, 8'd2, 1'b0}, 1'b0, '0},
      '{'{24'sh007000, 1'b1, 8'd3, 1'b1}, 1'b1,
        '{8'd3, 24'sh007000, 23'd0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{'{24'sh001000, 1'b1, 8'd4, 1'b0}, 1'b0, '0},
      '{'{24'sh003000, 1'b1, 8'd4, 1'b0}, 1'b0, '0},
      '{'{24'sh000000, 1'b0, 8'd4, 1'b0}, 1'b0, '0},
      '{'{24'sh002000, 1'b1, 8'd4, 1'b0}, 1'b0, '0},
      '{'{24'shFFFFFD, 1'b1, 8'd5, 1'b0}, 1'b0, '0},
      '{'{24'sh000000, 1'b1, 8'd5, 1'b0}, 1'b0, '0},
      '{'{24'shFFFFFF, 1'b0, 8'd5, 1'b1}, 1'b0, '0},
      '{'{24'sh000100, 1'b1, 8'd5, 1'b0}, 1'b0, '0},
      '{'{24'sh000100, 1'b1, 8'd5, 1'b0}, 1'b0, '0},
      '{'{24'sh000100, 1'b1, 8'd6, 1'b0}, 1'b0, '0},
      '{'{24'sh7FFFFF, 1'b1, 8'd6, 1'b0}, 1'b0, '0},
      '{'{24'sh7FFFFF, 1'b1, 8'd6, 1'b0}, 1'b0, '0},
      '{'{24'sh800000, 1'b1, 8'd128, 1'b0}, 1'b0, '0},
      '{'{24'sh800000, 1'b1, 8'd128, 1'b0}, 1'b0, '0},
      '{'{24'sh800000, 1'b0, 8'd128, 1'b1}, 1'b1,
        '{8'd128, 24'sh800000, 23'd0, 8'd2, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{'{24'sh555555, 1'b0, 8'd170, 1'b0}, 1'b0, '0},
      '{'{24'shAAAAAA, 1'b0, 8'd170, 1'b0}, 1'b0, '0},
      '{'{24'sh000000, 1'b1, 8'd85, 1'b1}, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;

   rsp_type pending_stats[$];
   int mismatch_count = 0;
   int stuck_cycles = 0;
   bit sender_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   logic [GROUP_WIDTH-1:0] open_grp = '0;
   bit grp_open = 1'b0;
   longint acc_sum = 0;
   bit [63:0] acc_sumsq = '0;
   int acc_present = 0;
   int acc_length = 0;
   bit acc_overflow = 1'b0;

   grouped_mean_std_dev_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int idle_cycles(input bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit [63:0] floor_sqrt(input bit [63:0] x);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   function automatic rsp_type close_group_stats(input bit last);
      rsp_type r;
      longint n;
      longint q;
      bit [63:0] s1mag;
      bit [63:0] spread;
      bit [63:0] sd;
      r = '0;
      n = acc_present;
      r.closed_group = open_grp;
      r.present_count = COUNT_WIDTH'(acc_present);
      r.mean_defined = (n >= 1);
      r.std_defined = (n >= 2);
      r.count_overflow = acc_overflow;
      r.last_result = last;
      if (n >= 1) begin
         q = acc_sum / n;
         if ((acc_sum % n) != 0 && acc_sum < 0) q = q - 1;
         r.group_mean = SAMPLE_WIDTH'(q);
      end
      if (n >= 2) begin
         s1mag = (acc_sum < 0) ? -acc_sum : acc_sum;
         spread = (64'(n) * acc_sumsq - s1mag * s1mag) / (64'(n) * 64'(n - 1));
         sd = floor_sqrt(spread);
         r.group_std_dev = (sd > STD_LIMIT) ? STD_WIDTH'(STD_LIMIT) : STD_WIDTH'(sd);
      end
      return r;
   endfunction

   task automatic queue_expected(input rsp_type r);
      pending_stats.insert(pending_stats.size(), r);
   endtask

   task automatic account_sample(input req_type item);
      longint v;
      v = longint'($signed(item.sample_value));
      if (grp_open && item.group_id != open_grp) begin
         queue_expected(close_group_stats(!item.end_of_data));
         grp_open = 1'b0;
      end
      if (!grp_open) begin
         open_grp = item.group_id;
         grp_open = 1'b1;
         acc_sum = 0;
         acc_sumsq = '0;
         acc_present = 0;
         acc_length = 0;
         acc_overflow = 1'b0;
      end
      if (acc_length >= MAX_GROUP_LEN) begin
         acc_overflow = 1'b1;
      end else begin
         acc_length++;
         if (item.sample_present) begin
            acc_sum += v;
            acc_sumsq += 64'(v * v);
            acc_present++;
         end
      end
      if (item.end_of_data) begin
         queue_expected(close_group_stats(1'b1));
         grp_open = 1'b0;
      end
   endtask

   task automatic send_sample(input req_type item);
      int gap;
      bit taken;
      gap = idle_cycles(sender_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      account_sample(item);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input int grp, input longint got,
                                input longint want);
      if (got != want)
         report_mismatch($sformatf("group %0d %s got %0d expected %0d", grp, name, got, want));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_stats.size() == 0) begin
         report_mismatch($sformatf("result for group %0d with none expected", got.closed_group));
         return;
      end
      want = pending_stats.pop_front();
      compare_field("closed_group", want.closed_group, got.closed_group, want.closed_group);
      compare_field("group_mean", want.closed_group, got.group_mean, want.group_mean);
      compare_field("group_std_dev", want.closed_group, got.group_std_dev, want.group_std_dev);
      compare_field("present_count", want.closed_group, got.present_count, want.present_count);
      compare_field("mean_defined", want.closed_group, got.mean_defined, want.mean_defined);
      compare_field("std_defined", want.closed_group, got.std_defined, want.std_defined);
      compare_field("count_overflow", want.closed_group, got.count_overflow, want.count_overflow);
      compare_field("last_result", want.closed_group, got.last_result, want.last_result);
   endtask

   initial begin
      int hold;
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_quiet = !rsp_quiet;
         hold = idle_cycles(rsp_quiet);
         rsp_stall <= (hold > 0);
         repeat ((hold > 0) ? hold : $urandom_range(1, 4)) @(posedge clock);
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      req_type item;
      value_mode_type mode;
      logic [GROUP_WIDTH-1:0] prev_gid;
      logic signed [SAMPLE_WIDTH-1:0] center;
      int sent;
      int group_index;
      int len;
      bit end_here;
      bit all_missing;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_sample(DIRECTED_ROWS[i].item);
         if (DIRECTED_ROWS[i].literal) pending_stats[$] = DIRECTED_ROWS[i].outcome;
      end

      sent = 0;
      group_index = 0;
      prev_gid = '0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) prev_gid = GROUP_WIDTH'($urandom);
         else prev_gid = prev_gid + GROUP_WIDTH'($urandom_range(1, 255));
         if (group_index == 4) len = MAX_GROUP_LEN;
         else if (group_index == 12)
            len = $urandom_range(MAX_GROUP_LEN + 1, MAX_GROUP_LEN + 20);
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 40);
         else len = $urandom_range(1, 6);
         mode = value_mode_type'($urandom_range(0, 2));
         center = SAMPLE_WIDTH'($urandom);
         end_here = ($urandom_range(0, 3) == 0);
         all_missing = ($urandom_range(0, 9) == 0);
         sender_quiet = ($urandom_range(0, 5) == 0);
         for (int k = 0; k < len; k++) begin
            item.group_id = prev_gid;
            item.sample_present = !all_missing && ($urandom_range(0, 7) != 0);
            item.end_of_data = end_here && (k == len - 1);
            case (mode)
               SPREAD_WIDE: begin
                  item.sample_value = SAMPLE_WIDTH'($urandom);
               end
               SPREAD_NARROW: begin
                  item.sample_value =
                     SAMPLE_WIDTH'(int'(center) + int'($urandom_range(0, 1023)) - 512);
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0: item.sample_value = 24'sh7FFFFF;
                     1: item.sample_value = 24'sh800000;
                     2: item.sample_value = 24'sh000000;
                     3: item.sample_value = 24'shFFFFFF;
                     default: item.sample_value = SAMPLE_WIDTH'($urandom);
                  endcase
               end
            endcase
            send_sample(item);
            sent++;
         end
         group_index++;
      end

      if (grp_open) begin
         item = '0;
         item.group_id = open_grp;
         item.sample_present = 1'b1;
         item.end_of_data = 1'b1;
         send_sample(item);
      end
      req_valid <= 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/gmsd_pkg.sv
hdl/gmsd_front.sv
hdl/gmsd_queue.sv
hdl/gmsd_back.sv
hdl/grouped_mean_std_dev_core.sv
sim/grouped_mean_std_dev_core_tb.sv
